@@ hw/rtl/cbc_pkg.sv @@
// Shared types, constants and tables for the color blob centroid block.
package cbc_pkg;

    // Field widths
    localparam int COLOR_W   = 8;
    localparam int POS_W     = 11;
    localparam int DIM_W     = 12;
    localparam int CNT_W     = 23;
    localparam int SUM_W     = 34;
    localparam int STEP_W    = 5;
    localparam int OFS_W     = 12;
    localparam int LVL_BITS  = 3;
    localparam int TBL_AW    = 3 * LVL_BITS;
    localparam int TBL_DEPTH = 1 << TBL_AW;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CNT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_COUNT = 2'd0,
        CFG_STEP      = 2'd1,
        CFG_WIDTH     = 2'd2,
        CFG_HEIGHT    = 2'd3
    } t_cfg_idx;

    // Register reset values
    localparam logic [CNT_W-1:0]  MIN_COUNT_RST = CNT_W'(60);
    localparam logic [STEP_W-1:0] STEP_RST      = STEP_W'(2);
    localparam logic [DIM_W-1:0]  WIDTH_RST     = DIM_W'(640);
    localparam logic [DIM_W-1:0]  HEIGHT_RST    = DIM_W'(480);
    localparam logic [OFS_W-1:0]  OFS_RST       = '1;

    // Word item kinds carried on tuser
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_TABLE = 1'b1;

    // Input tdata layout, lowest bit first
    localparam int IN_DATA_W = 56;
    localparam int RED_LSB   = 0;
    localparam int GREEN_LSB = RED_LSB + COLOR_W;
    localparam int BLUE_LSB  = GREEN_LSB + COLOR_W;
    localparam int ROW_LSB   = BLUE_LSB + COLOR_W;
    localparam int COL_LSB   = ROW_LSB + POS_W;
    localparam int IDX_LSB   = COL_LSB + POS_W;
    localparam int MATCH_LSB = IDX_LSB + TBL_AW;

    // Output tdata layout: x_offset, then y_offset
    localparam int OUT_DATA_W = 24;

    // Reciprocal divide-by-step: q = (n * RECIP) >> RECIP_SH, exact for n < 2^POS_W
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int QPROD_W  = POS_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_TBL [1 << STEP_W] = '{
        17'd65536, 17'd65536, 17'd32768, 17'd21846, 17'd16384, 17'd13108, 17'd10923,
        17'd9363,  17'd8192,  17'd7282,  17'd6554,  17'd5958,  17'd5462,  17'd5042,
        17'd4682,  17'd4370,  17'd4096,  17'd3856,  17'd3641,  17'd3450,  17'd3277,
        17'd3121,  17'd2979,  17'd2850,  17'd2731,  17'd2622,  17'd2521,  17'd2428,
        17'd2341,  17'd2260,  17'd2185,  17'd2115
    };

    // Divider
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // Controller states
    typedef enum logic [2:0] {
        S_RUN,
        S_FLUSH1,
        S_FLUSH2,
        S_CHK,
        S_DIV,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;
        logic chk;
        logic div_step;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic found;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

@@ hw/rtl/cbc_ctrl.sv @@
// Frame sequencer: input acceptance, pipeline drain, divide and result hand-off.
module cbc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_mode,
    input  logic          i_s_last,
    input  cbc_pkg::t_sts i_sts,
    output logic          o_s_ready,
    output cbc_pkg::t_cmd o_cmd
);

    cbc_pkg::t_state r_state;
    cbc_pkg::t_state n_state;
    logic            take;

    assign take = i_s_valid && (r_state == cbc_pkg::S_RUN);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbc_pkg::S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cbc_pkg::S_RUN: begin
                if (take && i_s_last && (i_s_mode == cbc_pkg::MODE_PIXEL)) begin
                    n_state = cbc_pkg::S_FLUSH1;
                end
            end
            cbc_pkg::S_FLUSH1: n_state = cbc_pkg::S_FLUSH2;
            cbc_pkg::S_FLUSH2: n_state = cbc_pkg::S_CHK;
            cbc_pkg::S_CHK: begin
                n_state = i_sts.found ? cbc_pkg::S_DIV : cbc_pkg::S_OUT;
            end
            cbc_pkg::S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = cbc_pkg::S_OUT;
                end
            end
            cbc_pkg::S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = cbc_pkg::S_RUN;
                end
            end
            default: n_state = cbc_pkg::S_RUN;
        endcase
    end

    // Outputs
    always_comb begin
        o_s_ready      = 1'b0;
        o_cmd          = '0;
        case (r_state)
            cbc_pkg::S_RUN: begin
                o_s_ready  = 1'b1;
                o_cmd.take = take;
            end
            cbc_pkg::S_CHK: o_cmd.chk      = 1'b1;
            cbc_pkg::S_DIV: o_cmd.div_step = 1'b1;
            cbc_pkg::S_OUT: o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/cbc_dpath.sv @@
// Datapath: config registers, class table, sample pipeline, moments, divider, output word.
module cbc_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [cbc_pkg::IN_DATA_W-1:0]     i_s_data,
    input  logic                              i_s_mode,
    input  cbc_pkg::t_cmd                     i_cmd,
    input  logic                              i_m_ready,
    output cbc_pkg::t_sts                     o_sts,
    output logic                              o_m_valid,
    output logic                              o_m_found,
    output logic [cbc_pkg::OFS_W-1:0]         o_m_x,
    output logic [cbc_pkg::OFS_W-1:0]         o_m_y
);

    localparam int PW  = cbc_pkg::POS_W;
    localparam int SW  = cbc_pkg::SUM_W;
    localparam int CW  = cbc_pkg::CNT_W;
    localparam int MW  = PW + cbc_pkg::STEP_W;

    // Configuration registers
    logic [CW-1:0]                    r_min_cnt;
    logic [cbc_pkg::STEP_W-1:0]       r_dstep;
    logic [cbc_pkg::RECIP_W-1:0]      r_recip;
    logic [cbc_pkg::DIM_W-1:0]        r_fw;
    logic [cbc_pkg::DIM_W-1:0]        r_fh;
    logic [cbc_pkg::STEP_W-1:0]       cfg_step;

    assign cfg_step = i_cfg_data[cbc_pkg::STEP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_cnt <= cbc_pkg::MIN_COUNT_RST;
            r_dstep   <= cbc_pkg::STEP_RST;
            r_recip   <= cbc_pkg::RECIP_TBL[cbc_pkg::STEP_RST];
            r_fw      <= cbc_pkg::WIDTH_RST;
            r_fh      <= cbc_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (cbc_pkg::t_cfg_idx'(i_cfg_idx))
                cbc_pkg::CFG_MIN_COUNT: r_min_cnt <= i_cfg_data;
                cbc_pkg::CFG_STEP: begin
                    // zero step behaves as one
                    r_dstep <= (cfg_step == '0) ? cbc_pkg::STEP_W'(1) : cfg_step;
                    r_recip <= cbc_pkg::RECIP_TBL[cfg_step];
                end
                cbc_pkg::CFG_WIDTH:  r_fw <= i_cfg_data[cbc_pkg::DIM_W-1:0];
                cbc_pkg::CFG_HEIGHT: r_fh <= i_cfg_data[cbc_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Input word fields
    logic [PW-1:0]              in_row;
    logic [PW-1:0]              in_col;
    logic [cbc_pkg::TBL_AW-1:0] tbl_raddr;
    logic [cbc_pkg::TBL_AW-1:0] tbl_waddr;
    logic                       tbl_wbit;

    assign in_row    = i_s_data[cbc_pkg::ROW_LSB +: PW];
    assign in_col    = i_s_data[cbc_pkg::COL_LSB +: PW];
    assign tbl_waddr = i_s_data[cbc_pkg::IDX_LSB +: cbc_pkg::TBL_AW];
    assign tbl_wbit  = i_s_data[cbc_pkg::MATCH_LSB];
    // top bits of each color form the table address, red highest
    assign tbl_raddr = {
        i_s_data[cbc_pkg::RED_LSB   + cbc_pkg::COLOR_W - 1 -: cbc_pkg::LVL_BITS],
        i_s_data[cbc_pkg::GREEN_LSB + cbc_pkg::COLOR_W - 1 -: cbc_pkg::LVL_BITS],
        i_s_data[cbc_pkg::BLUE_LSB  + cbc_pkg::COLOR_W - 1 -: cbc_pkg::LVL_BITS]
    };

    // Class table memory
    logic r_tbl [cbc_pkg::TBL_DEPTH];
    logic r_s1_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_s_mode == cbc_pkg::MODE_TABLE)) begin
            r_tbl[tbl_waddr] <= tbl_wbit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_hit <= r_tbl[tbl_raddr];
    end

    // Stage 1: quotients by step, frame bounds
    logic [cbc_pkg::QPROD_W-1:0] qprod_row;
    logic [cbc_pkg::QPROD_W-1:0] qprod_col;
    logic                        r_s1_vld;
    logic                        r_s1_in;
    logic [PW-1:0]               r_s1_row;
    logic [PW-1:0]               r_s1_col;
    logic [PW-1:0]               r_s1_qr;
    logic [PW-1:0]               r_s1_qc;

    assign qprod_row = cbc_pkg::QPROD_W'(in_row) * cbc_pkg::QPROD_W'(r_recip);
    assign qprod_col = cbc_pkg::QPROD_W'(in_col) * cbc_pkg::QPROD_W'(r_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.take && (i_s_mode == cbc_pkg::MODE_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_row <= in_row;
        r_s1_col <= in_col;
        r_s1_qr  <= qprod_row[cbc_pkg::RECIP_SH +: PW];
        r_s1_qc  <= qprod_col[cbc_pkg::RECIP_SH +: PW];
        r_s1_in  <= ({1'b0, in_row} < r_fh) && ({1'b0, in_col} < r_fw);
    end

    // Stage 2: divisibility check, sample qualifies
    logic [MW-1:0] back_row;
    logic [MW-1:0] back_col;
    logic          r_s2_vld;
    logic [PW-1:0] r_s2_row;
    logic [PW-1:0] r_s2_col;

    assign back_row = MW'(r_s1_qr) * MW'(r_dstep);
    assign back_col = MW'(r_s1_qc) * MW'(r_dstep);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld && r_s1_in && r_s1_hit &&
                        (back_row == MW'(r_s1_row)) && (back_col == MW'(r_s1_col));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_row <= r_s1_row;
        r_s2_col <= r_s1_col;
    end

    // Moments and restoring divider; sums shift into quotients during the divide
    logic [CW-1:0]                 r_cnt;
    logic [SW-1:0]                 r_row_sum;
    logic [SW-1:0]                 r_col_sum;
    logic [CW-1:0]                 r_rem_r;
    logic [CW-1:0]                 r_rem_c;
    logic [cbc_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic                          r_found;
    logic [CW:0]                   try_r;
    logic [CW:0]                   try_c;
    logic                          ge_r;
    logic                          ge_c;
    logic [CW-1:0]                 n_rem_r;
    logic [CW-1:0]                 n_rem_c;
    logic                          found;

    assign found   = r_cnt > r_min_cnt;
    assign try_r   = {r_rem_r, r_row_sum[SW-1]};
    assign try_c   = {r_rem_c, r_col_sum[SW-1]};
    assign ge_r    = try_r >= {1'b0, r_cnt};
    assign ge_c    = try_c >= {1'b0, r_cnt};
    assign n_rem_r = ge_r ? CW'(try_r - {1'b0, r_cnt}) : try_r[CW-1:0];
    assign n_rem_c = ge_c ? CW'(try_c - {1'b0, r_cnt}) : try_c[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_row_sum <= '0;
            r_col_sum <= '0;
            r_div_cnt <= '0;
            r_found   <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_cnt     <= '0;
            r_row_sum <= '0;
            r_col_sum <= '0;
        end else if (i_cmd.chk) begin
            r_found   <= found;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_row_sum <= {r_row_sum[SW-2:0], ge_r};
            r_col_sum <= {r_col_sum[SW-2:0], ge_c};
            r_div_cnt <= r_div_cnt + cbc_pkg::DIV_CNT_W'(1);
        end else if (r_s2_vld) begin
            r_cnt     <= r_cnt + CW'(1);
            r_row_sum <= r_row_sum + SW'(r_s2_row);
            r_col_sum <= r_col_sum + SW'(r_s2_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chk) begin
            r_rem_r <= '0;
            r_rem_c <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_r <= n_rem_r;
            r_rem_c <= n_rem_c;
        end
    end

    // Stored location and output register
    logic [cbc_pkg::OFS_W-1:0] r_st_x;
    logic [cbc_pkg::OFS_W-1:0] r_st_y;
    logic [cbc_pkg::OFS_W-1:0] n_st_x;
    logic [cbc_pkg::OFS_W-1:0] n_st_y;
    logic                      r_m_vld;
    logic                      r_m_found;
    logic [cbc_pkg::OFS_W-1:0] r_m_x;
    logic [cbc_pkg::OFS_W-1:0] r_m_y;

    // offsets from frame center, y pointing up, wrapped to 12 bits
    always_comb begin
        n_st_x = r_st_x;
        n_st_y = r_st_y;
        if (r_found) begin
            n_st_x = r_col_sum[cbc_pkg::OFS_W-1:0] - {1'b0, r_fw[cbc_pkg::DIM_W-1:1]};
            n_st_y = {1'b0, r_fh[cbc_pkg::DIM_W-1:1]} - r_row_sum[cbc_pkg::OFS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_x  <= cbc_pkg::OFS_RST;
            r_st_y  <= cbc_pkg::OFS_RST;
            r_m_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_st_x  <= n_st_x;
            r_st_y  <= n_st_y;
            r_m_vld <= 1'b1;
        end else if (i_m_ready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_found <= r_found;
            r_m_x     <= n_st_x;
            r_m_y     <= n_st_y;
        end
    end

    assign o_sts.found    = found;
    assign o_sts.div_last = (r_div_cnt == cbc_pkg::DIV_CNT_W'(SW - 1));
    assign o_sts.out_free = !r_m_vld || i_m_ready;
    assign o_m_valid      = r_m_vld;
    assign o_m_found      = r_m_found;
    assign o_m_x          = r_m_x;
    assign o_m_y          = r_m_y;

endmodule

@@ hw/rtl/color_blob_centroid.sv @@
// Top level of the color blob centroid block: controller plus datapath.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata pixel or table word, tuser kind, tlast
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata x/y offsets, tuser object_found
//  cfg       in   i_cfg_we                     i_cfg_idx, i_cfg_data
//
// Pixels and table writes are taken one word per cycle while the controller is in S_RUN.
// A last pixel closes the frame: S_FLUSH1 and S_FLUSH2 drain the sample pipeline, S_CHK
// compares the count, then a found object goes through the bit-serial restoring divider
// and S_OUT loads the result; input is held off from the frame end until that load.
// Reset is synchronous, active low; it restores register defaults and the stored
// location of -1,-1. The class table is not cleared. A result held by a stalled
// m_axis only blocks input at the next frame end.
module color_blob_centroid (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // red, green, blue, pixel_row, pixel_col, entry_index, entry_match
    input  logic [cbc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // mode
    input  logic                               s_axis_tuser,
    input  logic                               s_axis_tlast,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // x_offset, y_offset
    output logic [cbc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // object_found
    output logic                               m_axis_tuser
);

    cbc_pkg::t_cmd             cmd;
    cbc_pkg::t_sts             sts;
    logic [cbc_pkg::OFS_W-1:0] m_x;
    logic [cbc_pkg::OFS_W-1:0] m_y;

    cbc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_mode  (s_axis_tuser),
        .i_s_last  (s_axis_tlast),
        .i_sts     (sts),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    cbc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_data   (s_axis_tdata),
        .i_s_mode   (s_axis_tuser),
        .i_cmd      (cmd),
        .i_m_ready  (m_axis_tready),
        .o_sts      (sts),
        .o_m_valid  (m_axis_tvalid),
        .o_m_found  (m_axis_tuser),
        .o_m_x      (m_x),
        .o_m_y      (m_y)
    );

    assign m_axis_tdata = {m_y, m_x};

endmodule
